@@ design/matrix4x4_multiply_defines.svh @@
// Assertion macros for the matrix multiplier.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS
`define MM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("matrix4x4_multiply: same-cycle check failed");
`define MM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("matrix4x4_multiply: next-cycle check failed");
`else
`define MM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/mat4mul_pkg.sv @@
// Shared constants and types for the matrix multiplier.
package mat4mul_pkg;

	localparam int MATRIX_DIM_DEFAULT = 4;
	localparam int DATA_W             = 32;
	localparam int PROD_W             = 2 * DATA_W;
	localparam int FRAC_W             = 16;
	localparam int POS_OUT_W          = 4;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} mm_state_t;

endpackage

@@ design/matrix4x4_multiply.sv @@
// Matrix multiplier top level: element stores, MAC pipeline and result output.
// Results are paced by the single read port of each store feeding one product
// term per cycle. busy is high from the last load to the last result, and no
// new pair is loaded while busy. Reset clears the load position and pipeline
// control; the stores are not cleared. Results cannot be stalled by the receiver.
`include "matrix4x4_multiply_defines.svh"

module matrix4x4_multiply
	import mat4mul_pkg::*;
#(
	parameter int MATRIX_DIM = MATRIX_DIM_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [DATA_W-1:0]    a_element,
	input  logic signed [DATA_W-1:0]    b_element,
	output logic                        product_valid,
	output logic signed [DATA_W-1:0]    product_element,
	output logic [POS_OUT_W-1:0]        product_position,
	output logic                        last_element
);

	localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
	localparam int DIM_W = $clog2(MATRIX_DIM);
	localparam int POS_W = $clog2(CELLS);
	// full-precision sum of MATRIX_DIM products
	localparam int ACC_W = PROD_W + $clog2(MATRIX_DIM);
	localparam int SH_W  = ACC_W - FRAC_W;

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	mm_state_t state_q, state_d;

	logic [POS_W-1:0] load_pos_q;
	logic             load_en;
	logic             load_last;
	logic             issue_en;

	// loop counters: k innermost, then row, then column
	logic [DIM_W-1:0] k_q, row_q, col_q;
	logic             k_wrap, row_wrap, col_wrap, issue_done;

	// pipeline control
	logic vld_s1, first_s1, lastk_s1, lastcell_s1;
	logic vld_s2, first_s2, lastk_s2, lastcell_s2;
	logic sum_vld_s3, lastcell_s3;

	// payload
	logic signed [DATA_W-1:0] rd_a_s1, rd_b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic [POS_OUT_W-1:0]     out_pos_q;
	logic                     product_valid_q;
	logic signed [DATA_W-1:0] product_element_q;
	logic [POS_OUT_W-1:0]     product_position_q;
	logic                     last_element_q;

	// ---------------------------------------------------------------
	// Element stores: one write port (load), one registered read port.
	// Writes only happen while idle, read data is only used while busy, so the
	// state machine itself is the interlock; no forwarding needed.
	// ---------------------------------------------------------------
	logic [DATA_W-1:0] left_mem  [CELLS];
	logic [DATA_W-1:0] right_mem [CELLS];
	logic [POS_W-1:0]  addr_a, addr_b;

	assign load_en   = start && !busy;
	assign load_last = (load_pos_q == POS_W'(CELLS - 1));

	// A[k*D + r], B[c*D + k]
	assign addr_a = POS_W'(POS_W'(k_q) * POS_W'(MATRIX_DIM) + POS_W'(row_q));
	assign addr_b = POS_W'(POS_W'(col_q) * POS_W'(MATRIX_DIM) + POS_W'(k_q));

	always_ff @(posedge clk) begin
		if (load_en) begin
			left_mem[load_pos_q]  <= a_element;
			right_mem[load_pos_q] <= b_element;
		end
		rd_a_s1 <= left_mem[addr_a];
		rd_b_s1 <= right_mem[addr_b];
	end

	// ---------------------------------------------------------------
	// State machine
	// ---------------------------------------------------------------
	assign k_wrap     = (k_q == DIM_W'(MATRIX_DIM - 1));
	assign row_wrap   = (row_q == DIM_W'(MATRIX_DIM - 1));
	assign col_wrap   = (col_q == DIM_W'(MATRIX_DIM - 1));
	assign issue_done = k_wrap && row_wrap && col_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		issue_en = 1'b0;
		case (state_q)
			ST_LOAD: begin
				busy = 1'b0;
				if (load_en && load_last) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				issue_en = 1'b1;
				if (issue_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last sum is being saturated this cycle
				if (sum_vld_s3 && lastcell_s3) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Load position and loop counters
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			k_q        <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else begin
			if (load_en) begin
				load_pos_q <= load_last ? '0 : load_pos_q + 1'b1;
			end
			if (issue_en) begin
				k_q <= k_wrap ? '0 : k_q + 1'b1;
				if (k_wrap) begin
					row_q <= row_wrap ? '0 : row_q + 1'b1;
					if (row_wrap) begin
						col_q <= col_wrap ? '0 : col_q + 1'b1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// MAC pipeline: read -> multiply -> accumulate -> saturate
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			first_s1    <= 1'b0;
			lastk_s1    <= 1'b0;
			lastcell_s1 <= 1'b0;
			vld_s2      <= 1'b0;
			first_s2    <= 1'b0;
			lastk_s2    <= 1'b0;
			lastcell_s2 <= 1'b0;
			sum_vld_s3  <= 1'b0;
			lastcell_s3 <= 1'b0;
		end else begin
			vld_s1      <= issue_en;
			first_s1    <= (k_q == '0);
			lastk_s1    <= k_wrap;
			lastcell_s1 <= issue_done;
			vld_s2      <= vld_s1;
			first_s2    <= first_s1;
			lastk_s2    <= lastk_s1;
			lastcell_s2 <= lastcell_s1;
			sum_vld_s3  <= vld_s2 && lastk_s2;
			lastcell_s3 <= lastcell_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(rd_a_s1) * PROD_W'(rd_b_s1);
		if (vld_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	// floor shift by the fraction width, then clamp to 32 bits
	logic [SH_W-1:0]   shifted;
	logic              fits;
	logic [DATA_W-1:0] sat_value;

	always_comb begin
		shifted = acc_q[ACC_W-1:FRAC_W];
		fits    = (&shifted[SH_W-1:DATA_W-1]) || !(|shifted[SH_W-1:DATA_W-1]);
		if (fits) begin
			sat_value = shifted[DATA_W-1:0];
		end else if (shifted[SH_W-1]) begin
			sat_value = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat_value = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	// ---------------------------------------------------------------
	// Output register; position counts emitted items (4 bits, wraps)
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_valid_q <= 1'b0;
			last_element_q  <= 1'b0;
			out_pos_q       <= '0;
		end else begin
			product_valid_q <= sum_vld_s3;
			last_element_q  <= sum_vld_s3 && lastcell_s3;
			if (sum_vld_s3) begin
				out_pos_q <= lastcell_s3 ? '0 : out_pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_vld_s3) begin
			product_element_q  <= sat_value;
			product_position_q <= out_pos_q;
		end
	end

	assign product_valid    = product_valid_q;
	assign product_element  = product_element_q;
	assign product_position = product_position_q;
	assign last_element     = last_element_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`MM_ASSERT_NEXT(a_busy_after_last_load, clk, arst_n, load_en && load_last, busy)
	`MM_ASSERT_IMP(a_pipe_only_busy, clk, arst_n, vld_s1 || vld_s2 || sum_vld_s3, busy)
	`MM_ASSERT_NEXT(a_idle_after_last, clk, arst_n, product_valid && last_element, !busy)
	`MM_ASSERT_IMP(a_no_issue_on_load, clk, arst_n, load_en, !issue_en && !vld_s1)

endmodule

@@ verif/matrix4x4_multiply_test.sv @@
// Self-checking testbench for the 4x4 Q16.16 matrix multiplier.
module matrix4x4_multiply_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mat4mul_pkg::*;

	localparam int DIM   = MATRIX_DIM_DEFAULT;
	localparam int CELLS = DIM * DIM;
	localparam int ACC_W = PROD_W + 4;	// four products plus sign headroom

	localparam logic signed [ACC_W-1:0] Q_MAX = 2147483647;
	localparam logic signed [ACC_W-1:0] Q_MIN = -68'sd2147483648;

	// One product element as it should appear on the result ports
	typedef struct {
		logic signed [DATA_W-1:0]  element;
		logic [POS_OUT_W-1:0]      position;
		logic                      last;
	} product_t;

	// Keeps its own copy of both matrices and the load position, forms the
	// product once a pair is complete, and matches results in order.
	class product_checker;
		logic signed [DATA_W-1:0] left_cells[CELLS];
		logic signed [DATA_W-1:0] right_cells[CELLS];
		int       load_pos;
		product_t due_products[$];
		int       mismatches;
		int       products_seen;
		int       items_loaded;

		function new();
			load_pos = 0;
			mismatches = 0;
			products_seen = 0;
			items_loaded = 0;
		endfunction

		// Full-precision dot products, arithmetic shift by the fraction
		// width (floor), then clamp to the 32-bit signed range.
		function void multiply_matrices();
			logic signed [ACC_W-1:0]  acc;
			logic signed [PROD_W-1:0] term;
			logic signed [ACC_W-1:0]  shifted;
			product_t                 p;
			for (int pos = 0; pos < CELLS; pos++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++) begin
					term = left_cells[k*DIM + pos%DIM] * right_cells[(pos/DIM)*DIM + k];
					acc += term;
				end
				shifted = acc >>> FRAC_W;
				if (shifted > Q_MAX)
					shifted = Q_MAX;
				else if (shifted < Q_MIN)
					shifted = Q_MIN;
				p.element  = shifted[DATA_W-1:0];
				p.position = pos[POS_OUT_W-1:0];
				p.last     = (pos == CELLS - 1);
				due_products.push_back(p);
			end
		endfunction

		function void load_item(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
			left_cells[load_pos]  = a;
			right_cells[load_pos] = b;
			items_loaded++;
			load_pos++;
			if (load_pos == CELLS) begin
				load_pos = 0;
				multiply_matrices();
			end
		endfunction

		task flag_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task match_product(logic signed [DATA_W-1:0] element,
				logic [POS_OUT_W-1:0] position, logic last);
			product_t want;
			products_seen++;
			if (due_products.size() == 0) begin
				flag_mismatch($sformatf("unexpected product %h pos %0d last %b",
					element, position, last));
				return;
			end
			want = due_products.pop_front();
			if (element !== want.element)
				flag_mismatch($sformatf("pos %0d element %h, want %h",
					want.position, element, want.element));
			if (position !== want.position)
				flag_mismatch($sformatf("position %0d, want %0d", position, want.position));
			if (last !== want.last)
				flag_mismatch($sformatf("pos %0d last %b, want %b",
					want.position, last, want.last));
		endtask

		function int pending();
			return due_products.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [DATA_W-1:0] a_element;
	logic signed [DATA_W-1:0] b_element;
	logic                     product_valid;
	logic signed [DATA_W-1:0] product_element;
	logic [POS_OUT_W-1:0]     product_position;
	logic                     last_element;

	product_checker book = new();

	matrix4x4_multiply #(
		.MATRIX_DIM(DIM)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.a_element        (a_element),
		.b_element        (b_element),
		.product_valid    (product_valid),
		.product_element  (product_element),
		.product_position (product_position),
		.last_element     (last_element)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Results cannot be held off, so every strobe is checked at the edge
	// that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && product_valid)
			book.match_product(product_element, product_position, last_element);
	end

	// Called at a falling edge. Holds start high until an edge with busy low
	// takes the item; busy only moves on rising edges, so reading it here is
	// safe. Returns at the falling edge after acceptance.
	task automatic send_item(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
		start     <= 1'b1;
		a_element <= a;
		b_element <= b;
		while (busy)
			@(negedge clk);
		book.load_item(a, b);
		@(negedge clk);
	endtask

	// Random sender gap after an item; idle_pct is the chance per cycle.
	task automatic sender_gap(int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Mix of full-range words, modest Q16.16 values that mostly avoid
	// clamping, and the corner words.
	function automatic logic signed [DATA_W-1:0] pick_element();
		case ($urandom_range(4))
			0, 1:    return $urandom();
			2:       return $urandom_range(32'h7FFFF) - 32'h40000;
			3:       return $signed($urandom()) >>> $urandom_range(31);
			default: begin
				case ($urandom_range(5))
					0:       return 32'h7FFF_FFFF;
					1:       return 32'h8000_0000;
					2:       return 32'h0000_0000;
					3:       return 32'hFFFF_FFFF;
					4:       return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
		endcase
	endfunction

	task automatic random_pairs(int pairs, int idle_pct);
		for (int n = 0; n < pairs * CELLS; n++) begin
			send_item(pick_element(), pick_element());
			sender_gap(idle_pct);
		end
	endtask

	// Directed pair, column-major. Rows of A: all max, all min, 1.5, one
	// negative lsb. Columns of B: all max, all min, tiny positive, +2/-1
	// alternating. Gives both clamps (including min*min), a tiny negative
	// sum that floors to -1, and ordinary sums.
	task automatic directed_pair();
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		for (int i = 0; i < CELLS; i++) begin
			case (i % DIM)
				0:       a = 32'h7FFF_FFFF;
				1:       a = 32'h8000_0000;
				2:       a = 32'h0001_8000;
				default: a = 32'hFFFF_FFFF;
			endcase
			case (i / DIM)
				0:       b = 32'h7FFF_FFFF;
				1:       b = 32'h8000_0000;
				2:       b = 32'h0000_0003;
				default: b = ((i % DIM) % 2 == 0) ? 32'h0002_0000 : 32'hFFFF_0000;
			endcase
			send_item(a, b);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		a_element = '0;
		b_element = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_pair();

		// Pacing phases: back to back, sparse sender, back to back again
		// (receiver pressure does not apply), moderate sender gaps.
		random_pairs(2, 0);
		random_pairs(2, 87);
		random_pairs(1, 0);
		random_pairs(1, 33);
		start <= 1'b0;

		while (book.pending() > 0)
			@(posedge clk);
		// room for any stray extra result to show up
		repeat (4 * DIM + 8) @(posedge clk);

		$display("Loaded %0d items (%0d matrix pairs) over four pacing phases,",
			book.items_loaded, book.items_loaded / CELLS);
		$display("checked %0d product elements, %0d mismatches.",
			book.products_seen, book.mismatches);
		if (book.mismatches == 0) begin
			$display("PASS matrix4x4_multiply");
		end else begin
			$display("FAIL matrix4x4_multiply");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout, %0d products still due", book.pending());
		$display("FAIL matrix4x4_multiply");
		$finish;
	end

endmodule

@@ matrix4x4_multiply.f @@
+incdir+design
design/mat4mul_pkg.sv
design/matrix4x4_multiply.sv
verif/matrix4x4_multiply_test.sv
